// File: hw/rtl/lkms_pkg.sv
// Shared types, code constants and layer tables for the layered keypad scanner.
// No dependencies; the controller, datapath and top level import it.
`default_nettype none

package lkms_pkg;

    typedef logic [7:0] t_code;

    localparam int TAB_ROWS = 5;
    localparam int TAB_COLS = 8;
    localparam int TAB_IW   = 3;

    localparam t_code UP_MARK    = 8'h80;
    localparam t_code MODE_KEY   = 8'h7f;
    localparam t_code NUMCUR_KEY = 8'h7c;
    localparam t_code NO_DATA    = 8'hff;
    localparam t_code NO_CODE    = 8'h00;

    typedef enum logic [1:0] {
        MS_OFF   = 2'd0,
        MS_UP_ON = 2'd1,
        MS_DOWN  = 2'd2,
        MS_HOLD  = 2'd3
    } t_mode;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_WALK = 1'b1
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_dp_cmd;

    typedef struct packed {
        logic ends_walk;
        logic has_result;
        logic last_key;
        logic out_free;
    } t_dp_status;

    localparam t_code LAYER_NORMAL [TAB_ROWS][TAB_COLS] = '{
        '{8'h38, 8'h7f, 8'h1e, 8'h30, 8'h2e, 8'h20, 8'h00, 8'h00},
        '{8'h12, 8'h21, 8'h22, 8'h23, 8'h17, 8'h24, 8'h25, 8'h00},
        '{8'h26, 8'h32, 8'h31, 8'h18, 8'h19, 8'h10, 8'h13, 8'h00},
        '{8'h1f, 8'h14, 8'h16, 8'h2f, 8'h11, 8'h2d, 8'h15, 8'h00},
        '{8'h2c, 8'h2a, 8'h1d, 8'h39, 8'h7c, 8'h2b, 8'h1c, 8'h00}
    };

    localparam t_code LAYER_MODE [TAB_ROWS][TAB_COLS] = '{
        '{8'h00, 8'h00, 8'h02, 8'h03, 8'h04, 8'h05, 8'h00, 8'h00},
        '{8'h06, 8'h07, 8'h08, 8'h09, 8'h0a, 8'h0b, 8'h00, 8'h00},
        '{8'h0d, 8'h0c, 8'h37, 8'h35, 8'h0d, 8'h48, 8'h28, 8'h00},
        '{8'h01, 8'h33, 8'h34, 8'h00, 8'h4b, 8'h27, 8'h4d, 8'h00},
        '{8'h0f, 8'h00, 8'h3a, 8'h0e, 8'h00, 8'h50, 8'h00, 8'h00}
    };

    localparam t_code LAYER_NUMCUR [TAB_ROWS][TAB_COLS] = '{
        '{8'h00, 8'h00, 8'h02, 8'h03, 8'h04, 8'h05, 8'h00, 8'h00},
        '{8'h06, 8'h07, 8'h08, 8'h09, 8'h0a, 8'h0b, 8'h00, 8'h00},
        '{8'h0d, 8'h0c, 8'h00, 8'h00, 8'h00, 8'h48, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h4b, 8'h00, 8'h4d, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h50, 8'h00, 8'h00}
    };

endpackage

`default_nettype wire

// File: hw/rtl/lkms_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lkms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 40,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/lkms_ctrl.sv
// Walk controller: accepts a sample request and steps the datapath key by key.
// Depends on lkms_pkg.
`default_nettype none

module lkms_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire lkms_pkg::t_dp_status i_status,
    output lkms_pkg::t_dp_cmd        o_cmd
);
    import lkms_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (o_cmd.step && (i_status.ends_walk || i_status.last_key)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            ST_WALK: begin
                o_cmd.step = !i_status.has_result || i_status.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/lkms_dp.sv
// Scan datapath: sample register, layer translation, stored-code RAM, mode
// state and output register. Depends on lkms_pkg and lkms_ram.
`default_nettype none

module lkms_dp #(
    parameter int ROWS    = 5,
    parameter int COLUMNS = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire lkms_pkg::t_dp_cmd     i_cmd,
    output lkms_pkg::t_dp_status       o_status,
    input  wire logic [39:0]           i_key_matrix,
    input  wire logic                  i_out_stall,
    output logic                       o_out_valid,
    output lkms_pkg::t_code            o_scancode
);
    import lkms_pkg::*;

    localparam int NKEYS = ROWS * COLUMNS;
    localparam int KW    = (NKEYS > 1) ? $clog2(NKEYS) : 1;
    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

    logic [NKEYS-1:0] r_matrix;
    logic [NKEYS-1:0] r_valid;
    logic [KW-1:0]    r_key;
    logic [RW-1:0]    r_row;
    logic [CW-1:0]    r_col;
    logic             r_use_mode;
    logic             r_use_numcur;
    t_mode            r_mode;
    t_mode            n_mode;
    logic             r_numcur;
    logic             n_numcur;
    logic             r_out_valid;
    t_code            r_out_code;

    t_code            ram_rdata;
    t_code            old_code;
    t_code            now_code;
    t_code            alt_code;
    t_code            norm_code;
    t_code            store_code;
    t_code            emit_code;
    logic             changed;
    logic             ends_walk;
    logic             last_key;
    logic             ram_re;
    logic [KW-1:0]    ram_raddr;
    logic             ram_we;
    logic             out_taken;
    logic [TAB_IW-1:0] tab_r;
    logic [TAB_IW-1:0] tab_c;

    assign tab_r    = TAB_IW'(r_row);
    assign tab_c    = TAB_IW'(r_col);
    assign last_key = (r_key == KW'(NKEYS - 1));

    always_comb begin
        norm_code = LAYER_NORMAL[tab_r][tab_c];
        alt_code  = r_use_mode ? LAYER_MODE[tab_r][tab_c] : LAYER_NUMCUR[tab_r][tab_c];
        if (!r_matrix[r_key]) begin
            now_code = NO_CODE;
        end else if ((r_use_mode || r_use_numcur) && (alt_code != NO_CODE)) begin
            now_code = alt_code;
        end else begin
            now_code = norm_code;
        end
    end

    assign old_code = r_valid[r_key] ? ram_rdata : NO_CODE;
    assign changed  = (old_code != now_code);

    always_comb begin
        n_mode     = r_mode;
        n_numcur   = r_numcur;
        store_code = now_code;
        emit_code  = now_code;
        ends_walk  = 1'b0;
        if (changed) begin
            if ((now_code == NO_CODE) && (old_code != NO_CODE) && !old_code[7]) begin
                store_code = old_code | UP_MARK;
                emit_code  = old_code | UP_MARK;
                ends_walk  = 1'b1;
                if (n_mode == MS_UP_ON) begin
                    n_mode = MS_OFF;
                end
                if (old_code == MODE_KEY) begin
                    if (n_mode == MS_HOLD) begin
                        n_mode = MS_OFF;
                    end else if (n_mode == MS_DOWN) begin
                        n_mode = MS_UP_ON;
                    end
                end
                if (n_mode == MS_DOWN) begin
                    n_mode = MS_HOLD;
                end
            end else if (old_code[7]) begin
                store_code = NO_CODE;
                emit_code  = NO_CODE;
                ends_walk  = 1'b1;
            end else if (now_code == MODE_KEY) begin
                if (r_mode == MS_OFF) begin
                    n_mode = MS_DOWN;
                end
            end else if (now_code == NUMCUR_KEY) begin
                n_numcur = !r_numcur;
            end else begin
                ends_walk = 1'b1;
            end
        end
    end

    assign out_taken = r_out_valid && !i_out_stall;

    always_comb begin
        o_status.ends_walk  = ends_walk;
        o_status.has_result = ends_walk && (emit_code != NO_DATA);
        o_status.last_key   = last_key;
        o_status.out_free   = !r_out_valid || !i_out_stall;
    end

    assign ram_we    = i_cmd.step && changed;
    assign ram_re    = i_cmd.load || (i_cmd.step && !last_key);
    assign ram_raddr = i_cmd.load ? '0 : r_key + KW'(1);

    lkms_ram #(
        .WIDTH ($bits(t_code)),
        .DEPTH (NKEYS),
        .AW    (KW)
    ) u_codes (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_key),
        .i_wdata (store_code),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_matrix     <= i_key_matrix[NKEYS-1:0];
            r_use_mode   <= (r_mode != MS_OFF);
            r_use_numcur <= r_numcur;
        end
        if (i_cmd.step && o_status.has_result) begin
            r_out_code <= emit_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_key       <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_mode      <= MS_OFF;
            r_numcur    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_key <= '0;
                r_row <= '0;
                r_col <= '0;
            end else if (i_cmd.step) begin
                r_mode   <= n_mode;
                r_numcur <= n_numcur;
                if (changed) begin
                    r_valid[r_key] <= 1'b1;
                end
                if (!last_key) begin
                    r_key <= r_key + KW'(1);
                    if (r_row == RW'(ROWS - 1)) begin
                        r_row <= '0;
                        r_col <= r_col + CW'(1);
                    end else begin
                        r_row <= r_row + RW'(1);
                    end
                end
            end
            if (i_cmd.step && o_status.has_result) begin
                r_out_valid <= 1'b1;
            end else if (out_taken) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_scancode  = r_out_code;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> r_out_valid && $stable(r_out_code))
        else $error("pending scancode lost or changed under stall");

    a_load_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> (r_key == '0) && (r_row == '0) && (r_col == '0))
        else $error("walk did not restart at the first key");

    a_mode_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.step |=> $stable(r_mode) && $stable(r_numcur))
        else $error("layer state moved outside a key step");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step && o_status.has_result |-> o_status.out_free)
        else $error("result committed while output register busy");

endmodule

`default_nettype wire

// File: hw/rtl/layered_keypad_matrix_scanner_unit.sv
// Layered keypad matrix scanner, top level.
// Depends on lkms_pkg, lkms_ctrl, lkms_dp (and lkms_ram through lkms_dp).
//
// Input channel: i_in_valid / o_in_stall carry one request, a full sample of
// the key matrix on i_key_matrix (bit column*ROWS+row set for a pressed key).
// Output channel: o_out_valid / i_out_stall carry at most one scancode per
// request on o_scancode: a key-down code, a release code with bit 7 set, or
// 0x00 when a marked release is cleared.
// Timing: after acceptance the stored-code RAM is read for the first key,
// then one key is compared and committed per cycle through its single read
// port, unless a new result meets a full, stalled output register. The walk
// ends at the first changed key other than a mode or num/cursor key-down,
// or at the last key, and the next request is accepted in the cycle after
// that; a result enters the output register as its key is committed.
// The output register lets the next request be walked while a scancode waits;
// if a further scancode is found while the register is still full and
// stalled, the walk holds at that key until the register is taken.
// Reset clears the per-key valid bits (all stored codes read as zero), the
// mode and num/cursor state, the controller and the output valid.
`default_nettype none

module layered_keypad_matrix_scanner_unit #(
    parameter int ROWS    = 5,
    parameter int COLUMNS = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire logic [39:0]   i_key_matrix,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output lkms_pkg::t_code    o_scancode
);
    import lkms_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    lkms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    lkms_dp #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_key_matrix (i_key_matrix),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_scancode   (o_scancode)
    );

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// Self-checking bench for layered_keypad_matrix_scanner_unit: directed and random key samples,
// each scancode checked against an in-bench model of the layered scan and mode logic.
// Depends on lkms_pkg and the scanner RTL only.
module tb_top;
    import lkms_pkg::*;

    localparam int KEY_ROWS      = 5;
    localparam int KEY_COLS      = 8;
    localparam int KEY_COUNT     = KEY_ROWS * KEY_COLS;
    localparam int MODE_KEY_POS  = 1 * KEY_ROWS + 0;
    localparam int NUMCUR_KEY_POS = 4 * KEY_ROWS + 4;
    localparam int WALK_LATENCY  = 48;
    localparam int RANDOM_ITEMS  = 1800;

    typedef enum int {
        STALL_NONE,
        STALL_COIN,
        STALL_RUNS,
        STALL_EVERY_THIRD
    } t_stall_style;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic [39:0] i_key_matrix = '0;
    logic        i_out_stall  = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_code       o_scancode;

    t_code stored_codes [KEY_COUNT];
    t_mode mode_now   = MS_OFF;
    bit    numcur_now = 1'b0;
    t_code expected_codes [$];

    int error_count      = 0;
    int samples_sent     = 0;
    int codes_checked    = 0;
    int mode_entries     = 0;
    int numcur_toggles   = 0;
    int suppressed_codes = 0;
    int burst_left       = 0;
    bit sender_calm      = 1'b0;

    t_stall_style stall_style = STALL_NONE;
    int           stall_phase_left = 0;
    int           stall_run = 0;
    int           stall_tick = 0;
    t_code        wanted_code;

    layered_keypad_matrix_scanner_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_key_matrix (i_key_matrix),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_scancode   (o_scancode)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #24_000_000;
        $display("layered_keypad_matrix_scanner_unit: mismatch");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    function automatic logic [39:0] key_at(input int row, input int col);
        return 40'd1 << (col * KEY_ROWS + row);
    endfunction

    function automatic void predict_scan(input logic [39:0] keys, output bit emits,
                                         output t_code code);
        t_code fresh [KEY_COUNT];
        t_code alt;
        t_code prior;
        int k;
        emits = 1'b0;
        code  = NO_CODE;
        for (int col = 0; col < KEY_COLS; col++) begin
            for (int row = 0; row < KEY_ROWS; row++) begin
                k = col * KEY_ROWS + row;
                fresh[k] = NO_CODE;
                if (keys[k]) begin
                    fresh[k] = LAYER_NORMAL[row][col];
                    if (mode_now != MS_OFF)
                        alt = LAYER_MODE[row][col];
                    else if (numcur_now)
                        alt = LAYER_NUMCUR[row][col];
                    else
                        alt = NO_CODE;
                    if (alt != NO_CODE)
                        fresh[k] = alt;
                end
            end
        end
        for (k = 0; k < KEY_COUNT; k++) begin
            prior = stored_codes[k];
            if (prior == fresh[k])
                continue;
            if (fresh[k] == NO_CODE && prior != NO_CODE && (prior & UP_MARK) == NO_CODE) begin
                stored_codes[k] = prior | UP_MARK;
                if (mode_now == MS_UP_ON)
                    mode_now = MS_OFF;
                if (prior == MODE_KEY) begin
                    if (mode_now == MS_HOLD)
                        mode_now = MS_OFF;
                    else if (mode_now == MS_DOWN)
                        mode_now = MS_UP_ON;
                end
                if (mode_now == MS_DOWN)
                    mode_now = MS_HOLD;
            end else if ((prior & UP_MARK) != NO_CODE) begin
                stored_codes[k] = NO_CODE;
            end else begin
                stored_codes[k] = fresh[k];
                if (fresh[k] == MODE_KEY) begin
                    if (mode_now == MS_OFF) begin
                        mode_now = MS_DOWN;
                        mode_entries++;
                    end
                    continue;
                end
                if (fresh[k] == NUMCUR_KEY) begin
                    numcur_now = !numcur_now;
                    numcur_toggles++;
                    continue;
                end
            end
            code  = stored_codes[k];
            emits = (code != NO_DATA);
            if (!emits)
                suppressed_codes++;
            break;
        end
    endfunction

    task automatic send_request(input logic [39:0] keys);
        bit    emits;
        t_code code;
        int    gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (sender_calm)
                gap = 0;
            else if ($urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 4);
            else
                gap = $urandom_range(5, 60);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid   <= 1'b1;
        i_key_matrix <= keys;
        do @(posedge i_clk); while (o_in_stall);
        predict_scan(keys, emits, code);
        if (emits)
            expected_codes.push_back(code);
        samples_sent++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (expected_codes.size() != 0) @(posedge i_clk);
        repeat (WALK_LATENCY) @(posedge i_clk);
    endtask

    task automatic test_extremes();
        send_request('0);
        send_request({40{1'b1}});
        send_request('0);
    endtask

    task automatic test_mode_layer();
        logic [39:0] mode_key;
        logic [39:0] digit;
        mode_key = key_at(0, 1);
        digit    = key_at(2, 0);
        send_request(mode_key);
        send_request(mode_key | digit);
        send_request(mode_key);
        send_request(mode_key);
        send_request('0);
        send_request('0);
        // tap the mode key alone, then use the layer once
        send_request(mode_key);
        send_request('0);
        send_request('0);
        send_request(digit);
        send_request('0);
    endtask

    task automatic test_numcur_layer();
        logic [39:0] toggle;
        logic [39:0] digit;
        toggle = key_at(4, 4);
        digit  = key_at(1, 0);
        send_request(toggle);
        send_request('0);
        send_request(digit);
        send_request(digit);
        send_request('0);
    endtask

    task automatic test_repress_and_layer_change();
        logic [39:0] first_key;
        logic [39:0] held_key;
        first_key = key_at(0, 0);
        held_key  = key_at(2, 0);
        send_request(first_key);
        send_request('0);
        send_request(first_key);
        send_request(first_key);
        send_request(held_key);
        send_request(held_key | key_at(0, 1));
        send_request(held_key | key_at(0, 1));
        send_request('0);
    endtask

    task automatic test_random_walk(input int count);
        logic [39:0] held;
        int choice;
        int flips;
        int pos;
        held = '0;
        for (int i = 0; i < count; i++) begin
            if (i % 150 == 0)
                sender_calm = ($urandom_range(0, 2) == 0);
            if (i == count / 2)
                drain_results();
            choice = $urandom_range(0, 99);
            if (choice < 35) begin
                // hold the sample so the walk moves on
            end else if (choice < 82) begin
                flips = $urandom_range(1, 2);
                for (int f = 0; f < flips; f++) begin
                    case ($urandom_range(0, 5))
                        0:       pos = MODE_KEY_POS;
                        1:       pos = NUMCUR_KEY_POS;
                        default: pos = $urandom_range(0, KEY_COUNT - 1);
                    endcase
                    held[pos] = ~held[pos];
                end
            end else if (choice < 90) begin
                held = '0;
            end else begin
                held = 40'({$urandom, $urandom});
            end
            send_request(held);
        end
    endtask

    always @(posedge i_clk) begin
        if (stall_phase_left == 0) begin
            stall_style      <= t_stall_style'($urandom_range(0, 3));
            stall_phase_left <= $urandom_range(64, 256);
        end else begin
            stall_phase_left <= stall_phase_left - 1;
        end
        stall_tick <= (stall_tick == 2) ? 0 : stall_tick + 1;
        case (stall_style)
            STALL_NONE:        i_out_stall <= 1'b0;
            STALL_COIN:        i_out_stall <= 1'($urandom_range(0, 1));
            STALL_EVERY_THIRD: i_out_stall <= (stall_tick == 0);
            default: begin
                if (stall_run > 0) begin
                    i_out_stall <= 1'b1;
                    stall_run   <= stall_run - 1;
                end else if ($urandom_range(0, 7) == 0) begin
                    i_out_stall <= 1'b1;
                    stall_run   <= $urandom_range(5, 60);
                end else begin
                    i_out_stall <= 1'b0;
                end
            end
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_codes.size() == 0) begin
                report_mismatch($sformatf("unexpected scancode %02h", o_scancode));
            end else begin
                wanted_code = expected_codes.pop_front();
                codes_checked++;
                if (o_scancode !== wanted_code)
                    report_mismatch($sformatf("scancode %02h, wanted %02h",
                                              o_scancode, wanted_code));
            end
        end
    end

    initial begin
        foreach (stored_codes[k])
            stored_codes[k] = NO_CODE;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_mode_layer();
        test_numcur_layer();
        test_repress_and_layer_change();
        drain_results();
        test_random_walk(RANDOM_ITEMS);
        drain_results();
        $display("Sent %0d key samples; checked %0d scancodes, %0d mode-key releases suppressed.",
                 samples_sent, codes_checked, suppressed_codes);
        $display("Mode layer entered %0d times, num/cursor layer toggled %0d times.",
                 mode_entries, numcur_toggles);
        if (error_count == 0)
            $display("layered_keypad_matrix_scanner_unit: match");
        else
            $display("layered_keypad_matrix_scanner_unit: mismatch");
        $finish;
    end
endmodule
